/* rtl/utilization_share_sampler_defines.svh */
// Assertion helpers used by the checker file.
`ifndef UTILIZATION_SHARE_SAMPLER_DEFINES_SVH
`define UTILIZATION_SHARE_SAMPLER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define USS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utilization_share_sampler: check failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define USS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utilization_share_sampler: check failed");

`endif

/* rtl/uss_pkg.sv */
`default_nettype none

package uss_pkg;

  localparam int ID_W      = 16;
  localparam int TICK_W    = 48;
  localparam int TIME_W    = 48;
  localparam int CFG_W     = 16;
  localparam int TOT_W     = 53;
  localparam int SHARE_W   = 10;
  localparam int ENTRY_W   = ID_W + TICK_W;
  // growth * 1000 fits in 58 bits
  localparam int NUM_W     = TICK_W + SHARE_W;
  // quotient bits produced; anything at or above 2^11 saturates anyway
  localparam int DIV_STEPS = 12;
  localparam int DIV_W     = TOT_W + DIV_STEPS - 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [SHARE_W-1:0] SHARE_FULL   = 10'd1000;
  localparam logic [CFG_W-1:0]   INTERVAL_RST = 16'd1000;

  typedef enum logic [2:0] {
    P_IDLE    = 3'b001,
    P_COLLECT = 3'b010,
    P_SKIP    = 3'b100
  } phase_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_NEW   = 8'b0000_0100,
    S_LATCH = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } seq_state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [TOT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SHARE_W-1:0] share;
  } div_rsp_t;

  // g * 1000 as 1024 - 16 - 8
  function automatic logic [NUM_W-1:0] times_full(input logic [TICK_W-1:0] g);
    logic [NUM_W-1:0] w;
    w = NUM_W'(g);
    times_full = (w << 10) - (w << 4) - (w << 3);
  endfunction

endpackage

`default_nettype wire

/* rtl/uss_ram.sv */
`default_nettype none

module uss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/uss_div.sv */
`default_nettype none

// Restoring divider, one compare-subtract per cycle, saturating quotient.
module uss_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire uss_pkg::div_req_t req_i,
  output uss_pkg::div_rsp_t      rsp_o
);

  import uss_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic                 ge;

  assign ge = rem_q >= dvs_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = DIV_W'(req_i.num);
      dvs_d  = DIV_W'(req_i.den) << (DIV_STEPS - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? rem_q - dvs_q : rem_q;
      dvs_d  = dvs_q >> 1;
      quo_d  = {quo_q[DIV_STEPS-2:0], ge};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.share = (quo_q > DIV_STEPS'(SHARE_FULL)) ? SHARE_FULL : quo_q[SHARE_W-1:0];

endmodule

`default_nettype wire

/* rtl/utilization_share_sampler.sv */
// A snapshot word is taken only while idle; busy stays low while words are collected.
// On the closing word of a non-empty, non-baseline snapshot busy rises and the shares come
// out in turn, each after a scan of the previous table (one entry a cycle, up to the first
// hit) and a 12-step serial divide, skipped when no ticks were spent. A share is strobed
// for one cycle; it cannot be stalled. Reset (rst_ni low, async) clears control state and
// sets interval_ms to 1000; the snapshot tables are not cleared, read only below fill counts.
`default_nettype none

module utilization_share_sampler #(
  parameter int MAX_SOURCES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // snapshot words
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [uss_pkg::TIME_W-1:0]    now_ms_i,
  input  wire logic [uss_pkg::ID_W-1:0]      source_id_i,
  input  wire logic [uss_pkg::TICK_W-1:0]    tick_count_i,
  input  wire logic                          end_of_snapshot_i,
  // interval register write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [uss_pkg::CFG_W-1:0]     cfg_data_i,
  // share results
  output logic                               result_valid_o,
  output logic      [uss_pkg::ID_W-1:0]      result_id_o,
  output logic      [uss_pkg::SHARE_W-1:0]   share_tenths_o,
  output logic                               last_share_o
);

  import uss_pkg::*;

  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CNT_W = $clog2(MAX_SOURCES + 1);

  // Two table banks ping-pong: cur_q names the bank being filled by the
  // current snapshot, the other bank holds the previous one. Swapping the
  // roles replaces a copy of the table.
  seq_state_e         state_q, state_d;
  phase_e             phase_q, phase_d;
  logic               cur_q, cur_d;
  logic               baseline_q, baseline_d;
  logic [CFG_W-1:0]   interval_q, interval_d;
  logic [TIME_W-1:0]  prev_time_q, prev_time_d;
  logic [CNT_W-1:0]   prev_count_q, prev_count_d;
  logic [TOT_W-1:0]   prev_total_q, prev_total_d;
  logic [CNT_W-1:0]   new_count_q, new_count_d;
  logic [TOT_W-1:0]   new_total_q, new_total_d;
  logic [CNT_W-1:0]   i_q, i_d;          // entry being reported
  logic [CNT_W-1:0]   j_q, j_d;          // previous-table read pointer
  logic               pend_q, pend_d;    // previous-table read in flight
  logic               valid_q, valid_d;

  // payload registers
  logic [ID_W-1:0]    cur_id_q, cur_id_d;
  logic [TICK_W-1:0]  cur_tick_q, cur_tick_d;
  logic [TICK_W-1:0]  grew_q, grew_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [TOT_W-1:0]   spent_q, spent_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic [SHARE_W-1:0] out_share_q, out_share_d;
  logic               out_last_q, out_last_d;

  // collection path
  logic               accept;
  logic               first_item;
  logic [TIME_W-1:0]  elapsed;
  logic               too_soon;
  logic               skip_item;
  logic [CNT_W-1:0]   cnt_base, cnt_after;
  logic [TOT_W-1:0]   tot_base, tot_after;
  logic               room;

  // table ports
  logic               ram_we;
  logic [IDX_W-1:0]   i_idx, j_idx;
  logic [IDX_W-1:0]   raddr0, raddr1;
  logic [ENTRY_W-1:0] rd0, rd1, new_rd, prev_rd;
  logic [ENTRY_W-1:0] wdata;
  logic [ID_W-1:0]    prev_id;
  logic [TICK_W-1:0]  prev_tick;

  // sequencer helpers
  logic               issue;
  logic               match;
  logic               emit;
  logic [SHARE_W-1:0] emit_share;
  logic               emit_last;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign accept     = start && (state_q == S_IDLE);
  assign first_item = (phase_q == P_IDLE);
  // wraps mod 2^48, so a clock that ran backwards looks far away
  assign elapsed    = now_ms_i - prev_time_q;
  assign too_soon   = baseline_q && (elapsed < TIME_W'(interval_q));
  assign skip_item  = first_item ? too_soon : (phase_q == P_SKIP);
  assign cnt_base   = first_item ? '0 : new_count_q;
  assign tot_base   = first_item ? '0 : new_total_q;
  // words past the table depth are dropped and not totaled
  assign room       = cnt_base < CNT_W'(MAX_SOURCES);
  assign cnt_after  = room ? cnt_base + CNT_W'(1) : cnt_base;
  assign tot_after  = room ? tot_base + TOT_W'(tick_count_i) : tot_base;

  assign wdata  = {source_id_i, tick_count_i};
  assign i_idx  = i_q[IDX_W-1:0];
  assign j_idx  = j_q[IDX_W-1:0];
  assign raddr0 = cur_q ? j_idx : i_idx;
  assign raddr1 = cur_q ? i_idx : j_idx;
  assign new_rd  = cur_q ? rd1 : rd0;
  assign prev_rd = cur_q ? rd0 : rd1;
  assign prev_id   = prev_rd[ENTRY_W-1:TICK_W];
  assign prev_tick = prev_rd[TICK_W-1:0];

  // lookup: one read issued a cycle, compared when its data lands;
  // the first hit in table order wins
  assign issue = j_q < prev_count_q;
  assign match = pend_q && (prev_id == cur_id_q);

  assign emit_last = (i_q + CNT_W'(1)) == new_count_q;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    cur_d        = cur_q;
    baseline_d   = baseline_q;
    interval_d   = interval_q;
    prev_time_d  = prev_time_q;
    prev_count_d = prev_count_q;
    prev_total_d = prev_total_q;
    new_count_d  = new_count_q;
    new_total_d  = new_total_q;
    i_d          = i_q;
    j_d          = j_q;
    pend_d       = pend_q;
    valid_d      = 1'b0;
    cur_id_d     = cur_id_q;
    cur_tick_d   = cur_tick_q;
    grew_d       = grew_q;
    num_d        = num_q;
    spent_d      = spent_q;
    out_id_d     = out_id_q;
    out_share_d  = out_share_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = num_q;
    div_req.den   = spent_q;
    emit         = 1'b0;
    emit_share   = '0;

    if (cfg_valid_i) begin
      interval_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (skip_item) begin
            phase_d = end_of_snapshot_i ? P_IDLE : P_SKIP;
          end else begin
            if (first_item) begin
              prev_time_d = now_ms_i;
            end
            ram_we      = room;
            new_count_d = cnt_after;
            new_total_d = tot_after;
            if (end_of_snapshot_i) begin
              phase_d = P_IDLE;
              if (baseline_q && (cnt_after != '0)) begin
                state_d = S_PREP;
              end else begin
                // baseline or empty snapshot: just becomes the previous one
                cur_d        = ~cur_q;
                prev_count_d = cnt_after;
                prev_total_d = tot_after;
                baseline_d   = 1'b1;
              end
            end else begin
              phase_d = P_COLLECT;
            end
          end
        end
      end
      S_PREP: begin
        spent_d = (new_total_q > prev_total_q) ? new_total_q - prev_total_q : '0;
        i_d     = '0;
        state_d = S_NEW;
      end
      S_NEW: begin
        state_d = S_LATCH;
      end
      S_LATCH: begin
        cur_id_d   = new_rd[ENTRY_W-1:TICK_W];
        cur_tick_d = new_rd[TICK_W-1:0];
        j_d        = '0;
        pend_d     = 1'b0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        j_d    = issue ? j_q + CNT_W'(1) : j_q;
        pend_d = issue;
        if (match) begin
          grew_d  = (cur_tick_q > prev_tick) ? cur_tick_q - prev_tick : '0;
          state_d = S_MUL;
        end else if (!pend_q && !issue) begin
          // id not in the previous snapshot
          grew_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        num_d   = times_full(grew_q);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (spent_q == '0) begin
          emit = 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          emit       = 1'b1;
          emit_share = div_rsp.share;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      valid_d     = 1'b1;
      out_id_d    = cur_id_q;
      out_share_d = emit_share;
      out_last_d  = emit_last;
      if (emit_last) begin
        state_d      = S_IDLE;
        cur_d        = ~cur_q;
        prev_count_d = new_count_q;
        prev_total_d = new_total_q;
        baseline_d   = 1'b1;
      end else begin
        i_d     = i_q + CNT_W'(1);
        state_d = S_NEW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= P_IDLE;
      cur_q        <= 1'b0;
      baseline_q   <= 1'b0;
      interval_q   <= INTERVAL_RST;
      prev_time_q  <= '0;
      prev_count_q <= '0;
      prev_total_q <= '0;
      new_count_q  <= '0;
      new_total_q  <= '0;
      i_q          <= '0;
      j_q          <= '0;
      pend_q       <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      cur_q        <= cur_d;
      baseline_q   <= baseline_d;
      interval_q   <= interval_d;
      prev_time_q  <= prev_time_d;
      prev_count_q <= prev_count_d;
      prev_total_q <= prev_total_d;
      new_count_q  <= new_count_d;
      new_total_q  <= new_total_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_q       <= pend_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_id_q    <= cur_id_d;
    cur_tick_q  <= cur_tick_d;
    grew_q      <= grew_d;
    num_q       <= num_d;
    spent_q     <= spent_d;
    out_id_q    <= out_id_d;
    out_share_q <= out_share_d;
    out_last_q  <= out_last_d;
  end

  uss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SOURCES)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (ram_we && !cur_q),
    .waddr_i (cnt_base[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr0),
    .rdata_o (rd0)
  );

  uss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SOURCES)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (ram_we && cur_q),
    .waddr_i (cnt_base[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr1),
    .rdata_o (rd1)
  );

  uss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = valid_q;
  assign result_id_o    = out_id_q;
  assign share_tenths_o = out_share_q;
  assign last_share_o   = out_last_q;

endmodule

`default_nettype wire

/* rtl/uss_checker.sv */
`default_nettype none
`include "utilization_share_sampler_defines.svh"

module uss_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        result_valid_o,
  input wire logic [uss_pkg::SHARE_W-1:0] share_tenths_o,
  input wire logic                        last_share_o
);

  import uss_pkg::*;

  // shares come only out of a busy run
  `USS_ASSERT_IMPL(a_share_from_run, result_valid_o, $past(busy))
  // a share that is not the last leaves the block busy for the next one
  `USS_ASSERT_IMPL(a_more_to_come, result_valid_o && !last_share_o, busy)
  // saturated share range
  `USS_ASSERT_IMPL(a_share_range, result_valid_o, share_tenths_o <= SHARE_FULL)
  // each share needs a lookup (and a divide unless nothing was spent), never two strobes in a row
  `USS_ASSERT_NEXT(a_share_gap, result_valid_o && !last_share_o, !result_valid_o)
  // a run only starts from an accepted word
  `USS_ASSERT_IMPL(a_busy_cause, $rose(busy), $past(start))

endmodule

bind utilization_share_sampler uss_checker u_uss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .share_tenths_o (share_tenths_o),
  .last_share_o   (last_share_o)
);

`default_nettype wire
